[hw/rtl/idd_pkg.sv]
// ----------------------------------------------------------------------------
// idd_pkg
// Shared types, constants and helpers of the in-band escape deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package idd_pkg;

    localparam logic [7:0] IDD_PREFIX0 = 8'hFE;
    localparam logic [7:0] IDD_PREFIX1 = 8'hED;
    localparam logic [7:0] IDD_PREFIX2 = 8'hC0;

    localparam logic [3:0] IDD_PREFIX_LEN = 4'd3;
    localparam logic [3:0] IDD_CODE_POS   = 4'd3;
    localparam logic [3:0] IDD_FRAME_LAST = 4'd7;

    localparam int IDD_QUEUE_DEPTH = 4;

    localparam logic IDD_KIND_BYTE = 1'b0;
    localparam logic IDD_KIND_CMD  = 1'b1;

    // One unit of work for the back end: held prefix bytes to flush,
    // followed by an optional tail (pass-through byte or command).
    typedef struct packed {
        logic [1:0]  flush_cnt;
        logic        has_tail;
        logic        is_cmd;
        logic [7:0]  data;
        logic [31:0] arg;
    } t_job;

    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = IDD_PREFIX0;
            2'd1:    v = IDD_PREFIX1;
            default: v = IDD_PREFIX2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/idd_if.sv]
// ----------------------------------------------------------------------------
// idd_if
// Valid/ready channels of the deframer: host byte in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface idd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;

    modport source (output valid, output host_byte, input ready);
    modport sink   (input valid, input host_byte, output ready);
endinterface

interface idd_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  command_code;
    logic [31:0] command_arg;
    logic        last_of_run;

    modport source (output valid, output out_kind, output out_byte, output command_code,
                    output command_arg, output last_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input command_code,
                    input command_arg, input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/inband_escape_deframer_core.sv]
// ----------------------------------------------------------------------------
// inband_escape_deframer_core
// Host byte stream deframer: passes bytes through to the UART side and
// extracts escape-prefixed commands (FE ED C0, code, 32-bit LE argument).
//
// Channels: i_in carries one host byte per request; o_out carries one result
// per request (pass-through byte or command), with last_of_run marking the
// final result caused by an input byte. Both use valid/ready.
// Timing: a result passes from the front end through the job queue and the
// output register before it is valid on o_out. Prefix and frame bytes
// produce no result until the frame completes or a mismatch flushes the
// held bytes.
// Throughput: one input byte per cycle while the job queue has room; the
// result side emits one result per cycle while o_out.ready is high, so a
// mismatch flush emits its up to three results one after another. The queue
// depth sets how long such bursts can be absorbed before i_in.ready drops.
// Reset: synchronous, active low; clears the match counter, the job queue
// and the output valid flag. No clearing pass is needed.
// Stall: while o_out.ready is low the output register holds its result, the
// queue fills, and i_in.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module inband_escape_deframer_core
    import idd_pkg::*;
#(
    parameter int QUEUE_DEPTH = IDD_QUEUE_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    idd_in_if.sink    i_in,
    idd_out_if.source o_out
);

    logic can_push;
    logic push;
    t_job job;
    logic head_valid;
    t_job head;
    logic pop;

    idd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_push (can_push),
        .o_push     (push),
        .o_job      (job)
    );

    idd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (job),
        .o_can_push   (can_push),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    idd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/idd_front.sv]
// ----------------------------------------------------------------------------
// idd_front
// Accepts host bytes, tracks the escape prefix and frame collection, and
// posts flush/forward/command jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module idd_front
    import idd_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    idd_in_if.sink i_in,
    input  wire    i_can_push,
    output logic   o_push,
    output t_job   o_job
);

    logic [3:0]  r_mc;
    logic [3:0]  n_mc;
    logic [7:0]  r_code;
    logic [7:0]  n_code;
    logic [31:0] r_arg;
    logic [31:0] n_arg;
    logic        accept;
    logic [7:0]  b;

    assign i_in.ready = i_can_push;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.host_byte;

    always_comb begin
        n_mc   = r_mc;
        n_code = r_code;
        n_arg  = r_arg;
        o_push = 1'b0;
        o_job  = '0;
        if (accept) begin
            if (r_mc < IDD_PREFIX_LEN) begin
                if (b == prefix_byte(r_mc[1:0])) begin
                    n_mc = r_mc + 4'd1;
                end else begin
                    o_push          = 1'b1;
                    o_job.flush_cnt = r_mc[1:0];
                    o_job.has_tail  = (b != IDD_PREFIX0);
                    o_job.is_cmd    = 1'b0;
                    o_job.data      = b;
                    n_mc            = (b == IDD_PREFIX0) ? 4'd1 : 4'd0;
                end
            end else begin
                n_mc = r_mc + 4'd1;
                if (r_mc == IDD_CODE_POS) begin
                    n_code = b;
                end else begin
                    n_arg = {b, r_arg[31:8]};
                end
                if (r_mc == IDD_FRAME_LAST) begin
                    o_push          = 1'b1;
                    o_job.flush_cnt = 2'd0;
                    o_job.has_tail  = 1'b1;
                    o_job.is_cmd    = 1'b1;
                    o_job.data      = r_code;
                    o_job.arg       = {b, r_arg[31:8]};
                    n_mc            = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= 4'd0;
        end else begin
            r_mc <= n_mc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_arg  <= n_arg;
    end

    a_mc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mc <= IDD_FRAME_LAST)
        else $error("match count out of range");

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && (o_job.has_tail || o_job.flush_cnt != 2'd0)))
        else $error("empty or unaccepted job pushed");

endmodule

`default_nettype wire

[hw/rtl/idd_fifo.sv]
// ----------------------------------------------------------------------------
// idd_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module idd_fifo
    import idd_pkg::*;
#(
    parameter int DEPTH = IDD_QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_data,
    output logic  o_can_push,
    output logic  o_head_valid,
    output t_job  o_head,
    input  wire   i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_can_push   = (r_cnt != CNT_FULL);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && o_can_push;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_can_push)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/idd_back.sv]
// ----------------------------------------------------------------------------
// idd_back
// Expands queued jobs into results, one per cycle while o_out is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idd_back
    import idd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    idd_out_if.source  o_out
);

    logic [1:0]  r_idx;
    logic [1:0]  total;
    logic        is_last;
    logic        load;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_byte;
    logic [7:0]  r_code;
    logic [31:0] r_arg;
    logic        r_last;
    logic        n_kind;
    logic [7:0]  n_byte;
    logic [7:0]  n_code;
    logic [31:0] n_arg;

    assign total   = i_head.flush_cnt + {1'b0, i_head.has_tail};
    assign is_last = ((r_idx + 2'd1) == total);
    assign load    = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop   = load && is_last;

    always_comb begin
        n_kind = IDD_KIND_BYTE;
        n_byte = 8'd0;
        n_code = 8'd0;
        n_arg  = 32'd0;
        if (r_idx < i_head.flush_cnt) begin
            n_byte = prefix_byte(r_idx);
        end else if (i_head.is_cmd) begin
            n_kind = IDD_KIND_CMD;
            n_code = i_head.data;
            n_arg  = i_head.arg;
        end else begin
            n_byte = i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_code <= n_code;
            r_arg  <= n_arg;
            r_last <= is_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_kind     = r_kind;
    assign o_out.out_byte     = r_byte;
    assign o_out.command_code = r_code;
    assign o_out.command_arg  = r_arg;
    assign o_out.last_of_run  = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 2'd2)
        else $error("result index out of range");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the in-band escape deframer. Host bytes go in over a valid/ready
// channel while a behavioral model in the bench tracks the prefix match and
// the frame collection and queues the results each byte should cause. Every
// result taken from the output channel is compared field by field against
// the oldest queued one. Directed runs cover pass-through extremes, prefix
// mismatches and a command frame. Random runs then mix well-formed frames,
// broken prefixes and noise under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------

module testbench
    import idd_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  code;
        logic [31:0] arg;
        logic        last;
    } t_deframe_result;

    logic clk;
    logic rst_n;

    idd_in_if  host_ch ();
    idd_out_if uart_ch ();

    inband_escape_deframer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (host_ch),
        .o_out   (uart_ch)
    );

    // bench copy of the deframer state
    logic [3:0] match_cnt;
    logic [7:0] held [8];
    logic [7:0] prefix_pat [3];

    t_deframe_result pending_results [$];

    int err_count;
    int sent_total;
    int stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic t_deframe_result byte_result(input logic [7:0] b);
        t_deframe_result r;
        r = '0;
        r.kind = IDD_KIND_BYTE;
        r.data = b;
        return r;
    endfunction

    task automatic deframe_predict(input logic [7:0] b);
        t_deframe_result burst [$];
        t_deframe_result r;
        int i;
        if (match_cnt < IDD_PREFIX_LEN) begin
            if (b == prefix_pat[match_cnt]) begin
                held[match_cnt[2:0]] = b;
                match_cnt = match_cnt + 4'd1;
            end else begin
                for (i = 0; i < match_cnt; i++) begin
                    burst.push_back(byte_result(held[i]));
                end
                match_cnt = 4'd0;
                if (b == IDD_PREFIX0) begin
                    held[0] = b;
                    match_cnt = 4'd1;
                end else begin
                    burst.push_back(byte_result(b));
                end
            end
        end else begin
            held[match_cnt[2:0]] = b;
            if (match_cnt == IDD_FRAME_LAST) begin
                r = '0;
                r.kind = IDD_KIND_CMD;
                r.code = held[IDD_CODE_POS[2:0]];
                r.arg  = {held[7], held[6], held[5], held[4]};
                burst.push_back(r);
                match_cnt = 4'd0;
            end else begin
                match_cnt = match_cnt + 4'd1;
            end
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[k]) begin
            pending_results.push_back(burst[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            host_ch.valid <= 1'b0;
            @(posedge clk);
        end
        host_ch.valid     <= 1'b1;
        host_ch.host_byte <= b;
        do @(posedge clk); while (!host_ch.ready);
        deframe_predict(b);
        sent_total++;
    endtask

    task automatic check_result();
        t_deframe_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0d data=%02h code=%02h arg=%08h",
                                      uart_ch.out_kind, uart_ch.out_byte,
                                      uart_ch.command_code, uart_ch.command_arg));
            return;
        end
        want = pending_results.pop_front();
        if (uart_ch.out_kind !== want.kind)
            report_mismatch($sformatf("out_kind %0d, want %0d", uart_ch.out_kind, want.kind));
        if (uart_ch.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", uart_ch.out_byte, want.data));
        if (uart_ch.command_code !== want.code)
            report_mismatch($sformatf("command_code %02h, want %02h",
                                      uart_ch.command_code, want.code));
        if (uart_ch.command_arg !== want.arg)
            report_mismatch($sformatf("command_arg %08h, want %08h",
                                      uart_ch.command_arg, want.arg));
        if (uart_ch.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0d, want %0d",
                                      uart_ch.last_of_run, want.last));
    endtask

    always @(posedge clk) begin
        if (rst_n && uart_ch.valid && uart_ch.ready) begin
            check_result();
        end
        uart_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // no request moving on either side for too long means a hang
    always @(posedge clk) begin
        if ((host_ch.valid && host_ch.ready) || (uart_ch.valid && uart_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_host_byte();
        logic [7:0] b;
        case ($urandom_range(5))
            0:       b = IDD_PREFIX0;
            1:       b = IDD_PREFIX1;
            2:       b = IDD_PREFIX2;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    task automatic test_pass_through();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(IDD_PREFIX1);
        send_byte(IDD_PREFIX2);
    endtask

    task automatic test_prefix_mismatch();
        // one held byte flushed ahead of a plain byte
        send_byte(IDD_PREFIX0);
        send_byte(8'h00);
        // two held bytes plus the plain byte
        send_byte(IDD_PREFIX0);
        send_byte(IDD_PREFIX1);
        send_byte(8'hFF);
        // FE after FE, then FE after FE ED restarts the match
        send_byte(IDD_PREFIX0);
        send_byte(IDD_PREFIX0);
        send_byte(IDD_PREFIX1);
        send_byte(IDD_PREFIX0);
        send_byte(8'h80);
    endtask

    task automatic test_command_frame();
        send_byte(IDD_PREFIX0);
        send_byte(IDD_PREFIX1);
        send_byte(IDD_PREFIX2);
        send_byte(IDD_PREFIX0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        int sel;
        int n;
        int i;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = sent_total + count;
        while (sent_total < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_byte(IDD_PREFIX0);
                send_byte(IDD_PREFIX1);
                send_byte(IDD_PREFIX2);
                for (i = 0; i < 5; i++) begin
                    send_byte(8'($urandom_range(255)));
                end
            end else if (sel < 75) begin
                send_byte(IDD_PREFIX0);
                if ($urandom_range(1)) begin
                    send_byte(IDD_PREFIX1);
                end
                send_byte(rand_host_byte());
            end else begin
                n = $urandom_range(4, 1);
                for (i = 0; i < n; i++) begin
                    send_byte(rand_host_byte());
                end
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        host_ch.valid     = 1'b0;
        host_ch.host_byte = 8'h00;
        uart_ch.ready     = 1'b0;
        match_cnt         = 4'd0;
        prefix_pat        = '{IDD_PREFIX0, IDD_PREFIX1, IDD_PREFIX2};
        foreach (held[k]) held[k] = 8'h00;
        err_count         = 0;
        sent_total        = 0;
        stall_cycles      = 0;
        send_idle_pct     = 24;
        recv_idle_pct     = 83;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_prefix_mismatch();
        test_command_frame();
        test_random_traffic(24, 83, 80);
        test_random_traffic(83, 24, 80);
        test_random_traffic(0, 0, 80);
        host_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/idd_pkg.sv
hw/rtl/idd_if.sv
hw/rtl/idd_front.sv
hw/rtl/idd_fifo.sv
hw/rtl/idd_back.sv
hw/rtl/inband_escape_deframer_core.sv
bench/testbench.sv
